@@ src/aobt_pkg.sv @@
// ----------------------------------------------------------------------------
// aobt_pkg
// Types and constants shared by the add-order top-of-book tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aobt_pkg;

  localparam logic [7:0]  TYPE_ADD  = 8'h41;
  localparam logic [7:0]  SIDE_BUY  = 8'h42;
  localparam logic [7:0]  SIDE_SELL = 8'h53;

  localparam logic [5:0]  OFS_TYPE   = 6'd0;
  localparam logic [5:0]  OFS_SIDE   = 6'd19;
  localparam logic [5:0]  OFS_SHR_LO = 6'd20;
  localparam logic [5:0]  OFS_SHR_HI = 6'd23;
  localparam logic [5:0]  OFS_PRC_LO = 6'd32;
  localparam logic [5:0]  OFS_PRC_HI = 6'd35;
  localparam logic [5:0]  OFS_LIMIT  = 6'd36;

  localparam logic [31:0] SPREAD_LIMIT_RST = 32'h0000_1000;
  localparam logic [31:0] SHARE_FLOOR_RST  = 32'd100;
  localparam logic [31:0] ASK_NONE         = 32'hFFFF_FFFF;

  localparam logic CFG_SPREAD_LIMIT = 1'b0;
  localparam logic CFG_SHARE_FLOOR  = 1'b1;

  typedef struct packed {
    logic [7:0]  msg_type;
    logic [7:0]  side;
    logic [31:0] shares;
    logic [31:0] price;
  } cap_t;

  typedef struct packed {
    logic        buy_signal;
    logic [31:0] decisions_total;
    logic [31:0] ask_price;
    logic [31:0] bid_price;
  } res_t;

endpackage

@@ src/aobt_capture.sv @@
// ----------------------------------------------------------------------------
// aobt_capture
// Tracks the byte offset and captures the message fields of interest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aobt_capture (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         msg_byte,
  input  logic               end_of_message,
  output aobt_pkg::cap_t     cap_o
);

  logic [5:0]     offset_r;
  logic [5:0]     offset_nxt;
  aobt_pkg::cap_t cap_r;
  aobt_pkg::cap_t cap_nxt;

  // The captures including the current byte, so the final byte is seen.
  always_comb begin
    cap_nxt = cap_r;
    if (offset_r == aobt_pkg::OFS_TYPE) begin
      cap_nxt.msg_type = msg_byte;
    end else if (offset_r == aobt_pkg::OFS_SIDE) begin
      cap_nxt.side = msg_byte;
    end else if (offset_r >= aobt_pkg::OFS_SHR_LO && offset_r <= aobt_pkg::OFS_SHR_HI) begin
      cap_nxt.shares = {cap_r.shares[23:0], msg_byte};
    end else if (offset_r >= aobt_pkg::OFS_PRC_LO && offset_r <= aobt_pkg::OFS_PRC_HI) begin
      cap_nxt.price = {cap_r.price[23:0], msg_byte};
    end
    offset_nxt = (offset_r < aobt_pkg::OFS_LIMIT) ? offset_r + 6'd1 : offset_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      cap_r    <= '0;
    end else if (step) begin
      if (end_of_message) begin
        offset_r <= '0;
        cap_r    <= '0;
      end else begin
        offset_r <= offset_nxt;
        cap_r    <= cap_nxt;
      end
    end
  end

  assign cap_o = cap_nxt;

endmodule

@@ src/aobt_book.sv @@
// ----------------------------------------------------------------------------
// aobt_book
// Holds the best bid, best ask and decision count, and forms each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aobt_book (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  aobt_pkg::cap_t     cap_i,
  input  logic [31:0]        spread_limit,
  input  logic [31:0]        min_share_count,
  output aobt_pkg::res_t     res_o
);

  logic [31:0] bid_r;
  logic [31:0] ask_r;
  logic [31:0] count_r;
  logic        is_add;
  logic        raise_bid;
  logic        lower_ask;
  logic [31:0] bid_nxt;
  logic [31:0] ask_nxt;
  logic        crossed_ok;
  logic [31:0] spread;
  logic        decide;

  always_comb begin
    is_add    = (cap_i.msg_type == aobt_pkg::TYPE_ADD);
    raise_bid = is_add && (cap_i.side == aobt_pkg::SIDE_BUY) && (cap_i.price > bid_r);
    lower_ask = is_add && (cap_i.side == aobt_pkg::SIDE_SELL) && (cap_i.price < ask_r);
    bid_nxt   = raise_bid ? cap_i.price : bid_r;
    ask_nxt   = lower_ask ? cap_i.price : ask_r;

    // The spread is formed from whichever side moved, in parallel with the moves.
    if (raise_bid) begin
      crossed_ok = ask_r > cap_i.price;
      spread     = ask_r - cap_i.price;
    end else if (lower_ask) begin
      crossed_ok = cap_i.price > bid_r;
      spread     = cap_i.price - bid_r;
    end else begin
      crossed_ok = ask_r > bid_r;
      spread     = ask_r - bid_r;
    end

    decide = is_add && crossed_ok && (spread < spread_limit) &&
             (cap_i.shares > min_share_count);

    res_o.bid_price       = bid_nxt;
    res_o.ask_price       = ask_nxt;
    res_o.decisions_total = count_r + {31'd0, decide};
    res_o.buy_signal      = decide;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bid_r   <= '0;
      ask_r   <= aobt_pkg::ASK_NONE;
      count_r <= '0;
    end else if (step) begin
      bid_r   <= res_o.bid_price;
      ask_r   <= res_o.ask_price;
      count_r <= res_o.decisions_total;
    end
  end

endmodule

@@ src/itch_add_order_top_of_book_top.sv @@
// ----------------------------------------------------------------------------
// itch_add_order_top_of_book_top
// Byte-stream add-order parser with best bid/ask tracking and buy decisions.
// ----------------------------------------------------------------------------
// The block takes one message byte per cycle with tlast on the final byte and
// gives one result per message: the final byte passes the input register,
// then the parse and book logic into the output register. A byte that is not
// final never waits on the output side, and a final byte waits only while an
// earlier result is still held and not taken, so bytes are taken at one per
// cycle unless a held result stalls a final byte.
`timescale 1ns / 1ps

module itch_add_order_top_of_book_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] msg_byte
  input  logic         in_tlast,   // end_of_message
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // [31:0] bid_price, [63:32] ask_price,
                                   // [95:64] decisions_total
  output logic         out_tuser,  // buy_signal
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  logic           in_vld_r;
  logic [7:0]     in_byte_r;
  logic           in_eom_r;
  logic           advance;
  logic [31:0]    spread_limit_r;
  logic [31:0]    share_floor_r;
  logic           out_vld_r;
  aobt_pkg::res_t out_res_r;
  aobt_pkg::cap_t cap;
  aobt_pkg::res_t res;

  assign advance   = in_vld_r && (!in_eom_r || !out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_eom_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spread_limit_r <= aobt_pkg::SPREAD_LIMIT_RST;
      share_floor_r  <= aobt_pkg::SHARE_FLOOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        aobt_pkg::CFG_SPREAD_LIMIT: spread_limit_r <= cfg_data;
        aobt_pkg::CFG_SHARE_FLOOR:  share_floor_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  aobt_capture u_capture (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .msg_byte       (in_byte_r),
    .end_of_message (in_eom_r),
    .cap_o          (cap)
  );

  aobt_book u_book (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (advance && in_eom_r),
    .cap_i           (cap),
    .spread_limit    (spread_limit_r),
    .min_share_count (share_floor_r),
    .res_o           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && in_eom_r) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_eom_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_res_r.decisions_total, out_res_r.ask_price, out_res_r.bid_price};
  assign out_tuser  = out_res_r.buy_signal;

endmodule

@@ src/aobt_checker.sv @@
// ----------------------------------------------------------------------------
// aobt_checker
// Port-level checks for the add-order top-of-book tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aobt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic        out_tuser
);

  // A held item keeps its contents until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  // A decision is only made on an uncrossed book.
  a_signal_uncrossed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[63:32] > out_tdata[31:0])
    else $error("decision reported on a crossed or locked book");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind itch_add_order_top_of_book_top aobt_checker u_aobt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
